/* design/mhpq_pkg.sv */
`timescale 1ns / 1ps

package mhpq_pkg;

    // Heap geometry.
    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int IDX_W    = ADDR_W + 2;
    localparam int DATA_W   = 32;
    localparam int STAT_W   = 2;

    // Item operations.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Access request from the controller to the heap store.
    typedef struct packed {
        logic [ADDR_W-1:0]        rd_addr_a;
        logic [ADDR_W-1:0]        rd_addr_b;
        logic                     wr_en;
        logic [ADDR_W-1:0]        wr_addr;
        logic signed [DATA_W-1:0] wr_data;
    } mem_req_t;

    // Finished result handed to the output stage.
    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        logic [STAT_W-1:0]        status;
        logic [CNT_W-1:0]         entry_count;
    } result_t;

endpackage

/* design/mhpq_ram.sv */
`timescale 1ns / 1ps

// Simple synchronous memory: one write port, two read ports, registered read data.
module mhpq_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [DATA_W-1:0] rd_data_a,
    output logic [DATA_W-1:0] rd_data_b
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

/* design/mhpq_ctrl.sv */
`timescale 1ns / 1ps

// Heap sequencer: keeps the moving value in a register and walks a hole through the store.
module mhpq_ctrl (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  opcode,
    input  logic signed [mhpq_pkg::DATA_W-1:0]    push_value,
    output mhpq_pkg::mem_req_t                    mem_req,
    input  logic signed [mhpq_pkg::DATA_W-1:0]    rd_data_a,
    input  logic signed [mhpq_pkg::DATA_W-1:0]    rd_data_b,
    output logic                                  res_valid,
    input  logic                                  res_take,
    output mhpq_pkg::result_t                     res
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_UP_FIN,
        S_POP_RD,
        S_POP_TAKE,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } state_t;

    state_t                                state_reg, state_next;
    logic [mhpq_pkg::CNT_W-1:0]            occ_reg, occ_next;
    logic [mhpq_pkg::ADDR_W-1:0]           pos_reg, pos_next;
    logic signed [mhpq_pkg::DATA_W-1:0]    val_reg, val_next;
    logic signed [mhpq_pkg::DATA_W-1:0]    popped_reg, popped_next;
    logic [mhpq_pkg::STAT_W-1:0]           status_reg, status_next;

    logic                                  accept;
    logic [mhpq_pkg::ADDR_W-1:0]           pos_m1;
    logic [mhpq_pkg::ADDR_W-1:0]           parent;
    logic [mhpq_pkg::IDX_W-1:0]            left_idx;
    logic [mhpq_pkg::IDX_W-1:0]            right_idx;
    logic [mhpq_pkg::IDX_W-1:0]            occ_ext;
    logic                                  left_ok;
    logic                                  right_ok;
    logic                                  l_gt_v;
    logic                                  r_gt_v;
    logic                                  r_gt_l;
    logic                                  take_left;
    logic                                  take_right;
    logic [mhpq_pkg::CNT_W-1:0]            occ_dec;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    assign res.popped_value = popped_reg;
    assign res.status       = status_reg;
    assign res.entry_count  = occ_reg;

    // Index arithmetic for one heap level.
    assign pos_m1    = pos_reg - mhpq_pkg::ADDR_W'(1);
    assign parent    = {1'b0, pos_m1[mhpq_pkg::ADDR_W-1:1]};
    assign left_idx  = {1'b0, pos_reg, 1'b1};
    assign right_idx = left_idx + mhpq_pkg::IDX_W'(1);
    assign occ_ext   = {1'b0, occ_reg};
    assign left_ok   = (left_idx < occ_ext);
    assign right_ok  = (right_idx < occ_ext);
    assign occ_dec   = occ_reg - mhpq_pkg::CNT_W'(1);

    // Child selection: the left child wins unless the right one is strictly greater.
    assign l_gt_v     = (rd_data_a > val_reg);
    assign r_gt_v     = (rd_data_b > val_reg);
    assign r_gt_l     = (rd_data_b > rd_data_a);
    assign take_right = right_ok && (l_gt_v ? r_gt_l : r_gt_v);
    assign take_left  = l_gt_v && !take_right;

    always_comb
    begin
        state_next  = state_reg;
        occ_next    = occ_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        popped_next = popped_reg;
        status_next = status_reg;

        mem_req.rd_addr_a = parent;
        mem_req.rd_addr_b = occ_dec[mhpq_pkg::ADDR_W-1:0];
        mem_req.wr_en     = 1'b0;
        mem_req.wr_addr   = pos_reg;
        mem_req.wr_data   = val_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    popped_next = '0;
                    status_next = mhpq_pkg::ST_OK;
                    if (opcode == mhpq_pkg::OP_PUSH)
                    begin
                        if (occ_reg == mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY))
                        begin
                            status_next = mhpq_pkg::ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            pos_next   = occ_reg[mhpq_pkg::ADDR_W-1:0];
                            val_next   = push_value;
                            occ_next   = occ_reg + mhpq_pkg::CNT_W'(1);
                            state_next = (occ_reg == '0) ? S_UP_FIN : S_UP_RD;
                        end
                    end
                    else
                    begin
                        if (occ_reg == '0)
                        begin
                            status_next = mhpq_pkg::ST_EMPTY;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_POP_RD;
                        end
                    end
                end
            end

            S_UP_RD:
            begin
                state_next = S_UP_CMP;
            end

            S_UP_CMP:
            begin
                // Parent data sits on port A; a smaller parent moves down into the hole.
                mem_req.wr_en = 1'b1;
                if (val_reg > rd_data_a)
                begin
                    mem_req.wr_data = rd_data_a;
                    pos_next        = parent;
                    state_next      = (parent == '0) ? S_UP_FIN : S_UP_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_UP_FIN:
            begin
                mem_req.wr_en = 1'b1;
                state_next    = S_DONE;
            end

            S_POP_RD:
            begin
                mem_req.rd_addr_a = '0;
                state_next        = S_POP_TAKE;
            end

            S_POP_TAKE:
            begin
                popped_next = rd_data_a;
                val_next    = rd_data_b;
                occ_next    = occ_dec;
                pos_next    = '0;
                state_next  = (occ_dec == '0) ? S_DONE : S_DN_RD;
            end

            S_DN_RD:
            begin
                mem_req.rd_addr_a = left_idx[mhpq_pkg::ADDR_W-1:0];
                mem_req.rd_addr_b = right_idx[mhpq_pkg::ADDR_W-1:0];
                state_next        = S_DN_CMP;
            end

            S_DN_CMP:
            begin
                mem_req.wr_en = 1'b1;
                if (left_ok && take_right)
                begin
                    mem_req.wr_data = rd_data_b;
                    pos_next        = right_idx[mhpq_pkg::ADDR_W-1:0];
                    state_next      = S_DN_RD;
                end
                else if (left_ok && take_left)
                begin
                    mem_req.wr_data = rd_data_a;
                    pos_next        = left_idx[mhpq_pkg::ADDR_W-1:0];
                    state_next      = S_DN_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            occ_reg    <= '0;
            pos_reg    <= '0;
            val_reg    <= '0;
            popped_reg <= '0;
            status_reg <= mhpq_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            occ_reg    <= occ_next;
            pos_reg    <= pos_next;
            val_reg    <= val_next;
            popped_reg <= popped_next;
            status_reg <= status_next;
        end
    end

endmodule

/* design/max_heap_priority_queue_top.sv */
`timescale 1ns / 1ps
// One item is in work at a time: the input stalls from the accepting edge until the
// result word has moved into the output register. Each heap level climbed or
// descended takes a read state, then a compare and write-back state, on the single heap store.
// Reset clears the entry count and the control state; the store itself is not cleared.

module max_heap_priority_queue_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 opcode,
    input  logic signed [mhpq_pkg::DATA_W-1:0]   push_value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [mhpq_pkg::DATA_W-1:0]   popped_value,
    output logic [mhpq_pkg::STAT_W-1:0]          status,
    output logic [mhpq_pkg::CNT_W-1:0]           entry_count
);

    mhpq_pkg::mem_req_t                  mem_req;
    mhpq_pkg::result_t                   res;
    logic                                res_valid;
    logic                                res_take;
    logic [mhpq_pkg::DATA_W-1:0]         rd_data_a;
    logic [mhpq_pkg::DATA_W-1:0]         rd_data_b;

    logic                                out_valid_reg, out_valid_next;
    mhpq_pkg::result_t                   out_word_reg, out_word_next;

    // The heap store. Only entries below the entry count are ever read for a decision,
    // and each of those has been written by an earlier push or sift.
    mhpq_ram #(
        .DEPTH  (mhpq_pkg::CAPACITY),
        .DATA_W (mhpq_pkg::DATA_W)
    ) u_store (
        .clk       (clk),
        .wr_en     (mem_req.wr_en),
        .wr_addr   (mem_req.wr_addr),
        .wr_data   (mem_req.wr_data),
        .rd_addr_a (mem_req.rd_addr_a),
        .rd_addr_b (mem_req.rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // The sequencer walks the sift loop one heap level at a time.
    mhpq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .push_value (push_value),
        .mem_req    (mem_req),
        .rd_data_a  ($signed(rd_data_a)),
        .rd_data_b  ($signed(rd_data_b)),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res        (res)
    );

    // Output register: a finished word moves here as soon as the slot is free, so the
    // sequencer can take the next item while the consumer still holds off this one.
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_word_next  = res;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = out_word_reg.popped_value;
    assign status       = out_word_reg.status;
    assign entry_count  = out_word_reg.entry_count;

endmodule

/* tb/sv/max_heap_priority_queue_top_tb.sv */
`timescale 1ns / 1ps

module max_heap_priority_queue_top_tb;

    // The run is cut off here if the results stop coming. The slowest correct run
    // is a few thousand words, each costing its sifting plus random gaps on both
    // sides, so this leaves a wide margin.
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 500;
    // Extra cycles run after the last expected word has been checked.
    localparam int DRAIN_CYCLES = 40;

    // One row of the directed table. Where typed is set, the expected word is the
    // one written in the row; otherwise it comes from the heap predictor.
    typedef struct {
        logic                               op;
        logic signed [mhpq_pkg::DATA_W-1:0] value;
        bit                                 typed;
        mhpq_pkg::result_t                  res;
    } stim_row_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_stall;
    logic                               opcode = mhpq_pkg::OP_PUSH;
    logic signed [mhpq_pkg::DATA_W-1:0] push_value = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic signed [mhpq_pkg::DATA_W-1:0] popped_value;
    logic [mhpq_pkg::STAT_W-1:0]        status;
    logic [mhpq_pkg::CNT_W-1:0]         entry_count;

    // The testbench's own copy of the heap and of its entry count.
    logic signed [mhpq_pkg::DATA_W-1:0] model_heap [mhpq_pkg::CAPACITY];
    int                                 model_count = 0;

    // Result words still owed by the block, oldest first.
    mhpq_pkg::result_t                  expected_words [$];
    stim_row_t                          directed_rows [$];

    int                                 mismatch_count = 0;
    int                                 cycle_count = 0;
    // While calm is set neither side inserts idle cycles.
    bit                                 calm = 1'b0;

    max_heap_priority_queue_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .popped_value (popped_value),
        .status       (status),
        .entry_count  (entry_count)
    );

    always #10 clk = ~clk;

    // Heap predictor: applies one word to the model heap and returns the result word
    // that the block must produce for it.
    function automatic mhpq_pkg::result_t heap_predict(
        input logic op,
        input logic signed [mhpq_pkg::DATA_W-1:0] val);
        mhpq_pkg::result_t                  r;
        int                                 pos;
        int                                 up;
        int                                 left;
        int                                 right;
        int                                 best;
        logic signed [mhpq_pkg::DATA_W-1:0] tmp;
        r.popped_value = '0;
        r.status       = mhpq_pkg::ST_OK;
        if (op == mhpq_pkg::OP_PUSH)
        begin
            if (model_count >= mhpq_pkg::CAPACITY)
            begin
                r.status = mhpq_pkg::ST_FULL;
            end
            else
            begin
                // Append at the end and climb while the parent is strictly smaller.
                pos = model_count;
                model_heap[pos] = val;
                model_count++;
                while (pos > 0)
                begin
                    up = (pos - 1) / 2;
                    if (!(model_heap[pos] > model_heap[up]))
                        break;
                    tmp = model_heap[pos];
                    model_heap[pos] = model_heap[up];
                    model_heap[up] = tmp;
                    pos = up;
                end
            end
        end
        else
        begin
            if (model_count == 0)
            begin
                r.status = mhpq_pkg::ST_EMPTY;
            end
            else
            begin
                // Take the root, move the last entry up and let it sink. On equal
                // children the left one wins, since the right must be strictly greater.
                r.popped_value = model_heap[0];
                model_heap[0] = model_heap[model_count - 1];
                model_count--;
                pos = 0;
                forever
                begin
                    left  = 2 * pos + 1;
                    right = left + 1;
                    best  = pos;
                    if (left >= model_count)
                        break;
                    if (model_heap[left] > model_heap[best])
                        best = left;
                    if (right < model_count && model_heap[right] > model_heap[best])
                        best = right;
                    if (best == pos)
                        break;
                    tmp = model_heap[pos];
                    model_heap[pos] = model_heap[best];
                    model_heap[best] = tmp;
                    pos = best;
                end
            end
        end
        r.entry_count = mhpq_pkg::CNT_W'(model_count);
        return r;
    endfunction

    function automatic void add_row(input logic op,
                                    input logic signed [mhpq_pkg::DATA_W-1:0] val,
                                    input bit typed,
                                    input logic signed [mhpq_pkg::DATA_W-1:0] popped,
                                    input logic [mhpq_pkg::STAT_W-1:0] st,
                                    input int cnt);
        stim_row_t row;
        row.op                 = op;
        row.value              = val;
        row.typed              = typed;
        row.res.popped_value   = popped;
        row.res.status         = st;
        row.res.entry_count    = mhpq_pkg::CNT_W'(cnt);
        directed_rows.push_back(row);
    endfunction

    // Full-range values, with a fair share of the extremes and of a narrow
    // band, so that equal keys and the left-child tie break come up often.
    function automatic logic signed [mhpq_pkg::DATA_W-1:0] pick_value();
        logic signed [mhpq_pkg::DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = 32'sh7FFF_FFFF;
            1:       v = 32'sh8000_0000;
            2:       v = ($urandom_range(0, 1) != 0) ? 32'sh0 : -32'sd1;
            3, 4, 5: v = $signed(32'($urandom_range(0, 16))) - 32'sd8;
            default: v = $signed($urandom());
        endcase
        return v;
    endfunction

    // Presents one word on the input channel and holds it until it is taken. The
    // expected result is worked out at the edge of acceptance, so the model follows
    // the block in the same order. A random gap may follow; without one, valid just
    // stays high for the next word.
    task automatic send_word(input logic op,
                             input logic signed [mhpq_pkg::DATA_W-1:0] val,
                             input bit typed,
                             input mhpq_pkg::result_t typed_res);
        mhpq_pkg::result_t predicted;
        in_valid   <= 1'b1;
        opcode     <= op;
        push_value <= val;
        do
            @(posedge clk);
        while (in_stall);
        predicted = heap_predict(op, val);
        expected_words.push_back(typed ? typed_res : predicted);
        if (!calm && $urandom_range(0, 99) < 25)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic send_random(input logic op);
        mhpq_pkg::result_t none;
        none = '0;
        // A pop carries a random payload as well; the block must ignore it.
        send_word(op, (op == mhpq_pkg::OP_PUSH) ? pick_value() : $signed($urandom()),
                  1'b0, none);
    endtask

    // The receiving side stalls on about a quarter of the cycles, except while calm.
    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(0, 99) < 25);
    end

    // Each word taken from the output is checked against the oldest expectation.
    always @(posedge clk)
    begin
        mhpq_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: result word with none expected: popped_value %0d",
                         $time, popped_value);
                $display("%0t: status %0d entry_count %0d",
                         $time, status, entry_count);
                mismatch_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (popped_value !== want.popped_value)
                begin
                    $display("%0t: popped_value expected %0d actual %0d",
                             $time, want.popped_value, popped_value);
                    mismatch_count++;
                end
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, status);
                    mismatch_count++;
                end
                if (entry_count !== want.entry_count)
                begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.entry_count, entry_count);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: a hung block ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int        i;
        int        push_pct;
        stim_row_t row;

        // Directed table. The first eight rows and the last refused pop have
        // their words written out; the rest are left to the predictor.
        add_row(mhpq_pkg::OP_POP,  32'sh1234_5678, 1'b1, 32'sh0,
                mhpq_pkg::ST_EMPTY, 0);
        add_row(mhpq_pkg::OP_PUSH, 32'sh7FFF_FFFF, 1'b1, 32'sh0,
                mhpq_pkg::ST_OK, 1);
        add_row(mhpq_pkg::OP_PUSH, 32'sh8000_0000, 1'b1, 32'sh0,
                mhpq_pkg::ST_OK, 2);
        add_row(mhpq_pkg::OP_POP,  32'shFFFF_FFFF, 1'b1, 32'sh7FFF_FFFF,
                mhpq_pkg::ST_OK, 1);
        add_row(mhpq_pkg::OP_POP,  32'sh0,         1'b1, 32'sh8000_0000,
                mhpq_pkg::ST_OK, 0);
        add_row(mhpq_pkg::OP_POP,  32'sh7FFF_FFFF, 1'b1, 32'sh0,
                mhpq_pkg::ST_EMPTY, 0);
        add_row(mhpq_pkg::OP_PUSH, 32'sh0,         1'b1, 32'sh0,
                mhpq_pkg::ST_OK, 1);
        add_row(mhpq_pkg::OP_PUSH, -32'sd1,        1'b1, 32'sh0,
                mhpq_pkg::ST_OK, 2);
        // Values that climb to the root, equal keys and alternating bit patterns.
        add_row(mhpq_pkg::OP_PUSH, 32'sd5,         1'b0, 32'sh0, mhpq_pkg::ST_OK, 0);
        add_row(mhpq_pkg::OP_PUSH, 32'sd5,         1'b0, 32'sh0, mhpq_pkg::ST_OK, 0);
        add_row(mhpq_pkg::OP_PUSH, 32'sd3,         1'b0, 32'sh0, mhpq_pkg::ST_OK, 0);
        add_row(mhpq_pkg::OP_PUSH, 32'sh5555_5555, 1'b0, 32'sh0, mhpq_pkg::ST_OK, 0);
        add_row(mhpq_pkg::OP_PUSH, 32'shAAAA_AAAA, 1'b0, 32'sh0, mhpq_pkg::ST_OK, 0);
        add_row(mhpq_pkg::OP_PUSH, 32'sh7FFF_FFFF, 1'b0, 32'sh0, mhpq_pkg::ST_OK, 0);
        add_row(mhpq_pkg::OP_PUSH, 32'sh8000_0000, 1'b0, 32'sh0, mhpq_pkg::ST_OK, 0);
        // Nine entries are held now; drain them all, then pop once more on empty.
        for (i = 0; i < 9; i++)
            add_row(mhpq_pkg::OP_POP, 32'shDEAD_BEEF, 1'b0, 32'sh0, mhpq_pkg::ST_OK, 0);
        add_row(mhpq_pkg::OP_POP, 32'sh0, 1'b1, 32'sh0, mhpq_pkg::ST_EMPTY, 0);

        // Reset is held low from the start and released on a rising edge.
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
        begin
            row = directed_rows[k];
            send_word(row.op, row.value, row.typed, row.res);
        end

        // Random part: the push share falls over the run so the count first grows,
        // then wanders, then shrinks. The middle stretch runs with no idling at all.
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = (i >= 200 && i < 300);
            push_pct = (i < 200) ? 70 : (i < 350) ? 50 : 35;
            send_random(($urandom_range(0, 99) < push_pct) ? mhpq_pkg::OP_PUSH
                                                           : mhpq_pkg::OP_POP);
        end
        calm = 1'b0;

        // Fill the heap to capacity, push against the full heap, step off and back
        // onto the limit, then drain it to empty with the odd push mixed in.
        while (model_count < mhpq_pkg::CAPACITY)
            send_random(mhpq_pkg::OP_PUSH);
        repeat (3) send_random(mhpq_pkg::OP_PUSH);
        send_random(mhpq_pkg::OP_POP);
        send_random(mhpq_pkg::OP_PUSH);
        send_random(mhpq_pkg::OP_PUSH);
        while (model_count > 0)
            send_random(($urandom_range(0, 99) < 10) ? mhpq_pkg::OP_PUSH
                                                     : mhpq_pkg::OP_POP);
        repeat (2) send_random(mhpq_pkg::OP_POP);
        in_valid <= 1'b0;

        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
